@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the MDIO master RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mdiom_pkg.sv @@
// ---------------------------------------------------------------------------
// MDIO master package
// Constants, codes and beat types shared by the MDIO master modules.
// ---------------------------------------------------------------------------
package mdiom_pkg;

  localparam int PREAMBLE_BITS = 32;
  localparam int DIVIDER_BITS  = 8;
  localparam int DIV_W         = (DIVIDER_BITS < 8) ? DIVIDER_BITS : 8;
  localparam int FRAME_LEN     = PREAMBLE_BITS + 32;
  localparam int BIT_CNT_W     = $clog2(FRAME_LEN);

  localparam logic [BIT_CNT_W:0]   FRAME_END = (BIT_CNT_W + 1)'(FRAME_LEN);
  localparam logic [BIT_CNT_W-1:0] LAST_IDX  = BIT_CNT_W'(FRAME_LEN - 1);
  localparam logic [BIT_CNT_W-1:0] WORD_BITS = BIT_CNT_W'(32);
  localparam logic [BIT_CNT_W-1:0] RD_START  = BIT_CNT_W'(PREAMBLE_BITS + 16);
  localparam logic [BIT_CNT_W-1:0] DRV_END   = BIT_CNT_W'(PREAMBLE_BITS + 14);

  localparam logic [6:0] OFS_MODE  = 7'h40;
  localparam logic [6:0] OFS_ADDR  = 7'h44;
  localparam logic [6:0] OFS_WDATA = 7'h48;
  localparam logic [6:0] OFS_RDATA = 7'h4c;
  localparam logic [6:0] OFS_CMD   = 7'h50;

  localparam int CMD_START_BIT = 8;
  localparam int CMD_BUSY_BIT  = 16;
  localparam int MODE_C45_BIT  = 8;
  localparam int MODE_MDC_BIT  = 12;

  typedef enum logic [1:0] {
    BUS_READ  = 2'd0,
    BUS_WRITE = 2'd1,
    BUS_TICK  = 2'd2
  } bus_op_t;

  typedef enum logic [1:0] {
    ACC_ADDR     = 2'd0,
    ACC_WRITE    = 2'd1,
    ACC_READ     = 2'd2,
    ACC_READ_INC = 2'd3
  } acc_t;

  localparam logic [1:0] ST_C22      = 2'b01;
  localparam logic [1:0] ST_C45      = 2'b00;
  localparam logic [1:0] OP_ADDR     = 2'b00;
  localparam logic [1:0] OP_WRITE    = 2'b01;
  localparam logic [1:0] OP_READ_INC = 2'b10;
  localparam logic [1:0] OP_READ     = 2'b11;
  localparam logic [1:0] OP22_WRITE  = 2'b01;
  localparam logic [1:0] OP22_READ   = 2'b10;
  localparam logic [1:0] TA_DRIVEN   = 2'b10;
  localparam logic [1:0] TA_RELEASED = 2'b00;

  // Bit of the frame word that holds the high opcode bit (set on reads).
  localparam int FRAME_READ_BIT = 29;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  reg_offset;
    logic [31:0] write_data;
    logic        mdio_in;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
  } result_t;

endpackage

@@ src/mdiom_in_reg.sv @@
// ---------------------------------------------------------------------------
// MDIO master input register
// Holds one accepted input beat until the engine takes it.
// ---------------------------------------------------------------------------
module mdiom_in_reg import mdiom_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t item_in,
  input  logic  advance,
  output logic  item_valid,
  output item_t item_q
);

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || advance) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!item_valid || advance) && in_valid) begin
      item_q <= item_in;
    end
  end

endmodule

@@ src/mdiom_engine.sv @@
// ---------------------------------------------------------------------------
// MDIO master engine
// Register file, frame builder and bit timing; updates state once per beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mdiom_engine import mdiom_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic [DIV_W-1:0]     div, div_next;
  logic                 c45, c45_next;
  logic                 mdcmode, mdcmode_next;
  logic [4:0]           phy, phy_next;
  logic [4:0]           regad, regad_next;
  logic [15:0]          wdata, wdata_next;
  logic [15:0]          rdata, rdata_next;
  logic [1:0]           acc, acc_next;
  logic                 busy, busy_next;
  logic [DIV_W-1:0]     tick_cnt, tick_cnt_next;
  logic [BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [31:0]          frame, frame_next;

  logic [1:0]           st, op, ta;
  logic [15:0]          ldata;
  logic [31:0]          launch_word;
  logic [31:0]          rd;
  logic [BIT_CNT_W:0]   bit_inc;
  logic [DIV_W:0]       low_len;
  logic [BIT_CNT_W-1:0] idx;
  logic                 bit_val;
  logic                 drive;

  always_comb begin
    if (c45) begin
      st = ST_C45;
      unique case (acc_t'(item.write_data[1:0]))
        ACC_ADDR:     op = OP_ADDR;
        ACC_WRITE:    op = OP_WRITE;
        ACC_READ:     op = OP_READ;
        ACC_READ_INC: op = OP_READ_INC;
        default:      op = OP_READ;
      endcase
    end else begin
      st = ST_C22;
      op = (acc_t'(item.write_data[1:0]) == ACC_WRITE) ? OP22_WRITE : OP22_READ;
    end
    if (op[1]) begin
      ta    = TA_RELEASED;
      ldata = '0;
    end else begin
      ta    = TA_DRIVEN;
      ldata = wdata;
    end
    launch_word = {st, op, phy, regad, ta, ldata};
  end

  always_comb begin
    div_next      = div;
    c45_next      = c45;
    mdcmode_next  = mdcmode;
    phy_next      = phy;
    regad_next    = regad;
    wdata_next    = wdata;
    rdata_next    = rdata;
    acc_next      = acc;
    busy_next     = busy;
    tick_cnt_next = tick_cnt;
    bit_cnt_next  = bit_cnt;
    frame_next    = frame;
    rd            = '0;
    bit_inc       = {1'b0, bit_cnt} + 1'b1;
    if (fire) begin
      unique case (bus_op_t'(item.mode))
        BUS_READ: begin
          unique case (item.reg_offset)
            OFS_MODE: begin
              rd[DIV_W-1:0]   = div;
              rd[MODE_C45_BIT] = c45;
              rd[MODE_MDC_BIT] = mdcmode;
            end
            OFS_ADDR: begin
              rd[12:8] = phy;
              rd[4:0]  = regad;
            end
            OFS_WDATA: rd[15:0] = wdata;
            OFS_RDATA: rd[15:0] = rdata;
            OFS_CMD: begin
              rd[CMD_BUSY_BIT] = busy;
              rd[1:0]          = acc;
            end
            default: rd = '0;
          endcase
        end
        BUS_WRITE: begin
          unique case (item.reg_offset)
            OFS_MODE: begin
              div_next     = item.write_data[DIV_W-1:0];
              c45_next     = item.write_data[MODE_C45_BIT];
              mdcmode_next = item.write_data[MODE_MDC_BIT];
            end
            OFS_ADDR: begin
              phy_next   = item.write_data[12:8];
              regad_next = item.write_data[4:0];
            end
            OFS_WDATA: wdata_next = item.write_data[15:0];
            OFS_CMD: begin
              if (!busy) begin
                acc_next = item.write_data[1:0];
                if (item.write_data[CMD_START_BIT]) begin
                  frame_next    = launch_word;
                  busy_next     = 1'b1;
                  tick_cnt_next = '0;
                  bit_cnt_next  = '0;
                end
              end
            end
            default: ;
          endcase
        end
        BUS_TICK: begin
          if (busy) begin
            if (tick_cnt >= div) begin
              if (frame[FRAME_READ_BIT] && bit_cnt >= RD_START) begin
                rdata_next = {rdata[14:0], item.mdio_in};
              end
              tick_cnt_next = '0;
              if (bit_inc >= FRAME_END) begin
                busy_next    = 1'b0;
                bit_cnt_next = '0;
              end else begin
                bit_cnt_next = bit_inc[BIT_CNT_W-1:0];
              end
            end else begin
              tick_cnt_next = tick_cnt + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    low_len = (DIV_W + 1)'(div_next >> 1) + 1'b1;
    idx     = LAST_IDX - bit_cnt_next;
    bit_val = (idx >= WORD_BITS) ? 1'b1 : frame_next[idx[4:0]];
    drive   = busy_next && (bit_cnt_next < DRV_END || !frame_next[FRAME_READ_BIT]);
    result.read_data  = rd;
    result.mdc        = busy_next && ({1'b0, tick_cnt_next} >= low_len);
    result.mdio_out   = drive && bit_val;
    result.mdio_drive = drive;
    result.busy_res   = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div      <= '1;
      c45      <= 1'b0;
      mdcmode  <= 1'b0;
      phy      <= '0;
      regad    <= '0;
      wdata    <= '0;
      rdata    <= '0;
      acc      <= '0;
      busy     <= 1'b0;
      tick_cnt <= '0;
      bit_cnt  <= '0;
      frame    <= '0;
    end else begin
      div      <= div_next;
      c45      <= c45_next;
      mdcmode  <= mdcmode_next;
      phy      <= phy_next;
      regad    <= regad_next;
      wdata    <= wdata_next;
      rdata    <= rdata_next;
      acc      <= acc_next;
      busy     <= busy_next;
      tick_cnt <= tick_cnt_next;
      bit_cnt  <= bit_cnt_next;
      frame    <= frame_next;
    end
  end

  `CHECK_NOW(a_idle_bitcnt_zero, clk, rst, !busy, bit_cnt == '0, "bit count not zero while idle")
  `CHECK_NEXT(a_tick_idle_stays, clk, rst, fire && item.mode == BUS_TICK && !busy, !busy && tick_cnt == $past(tick_cnt), "tick changed an idle engine")
  `CHECK_NEXT(a_start_launches, clk, rst, fire && item.mode == BUS_WRITE && item.reg_offset == OFS_CMD && item.write_data[CMD_START_BIT] && !busy, busy && bit_cnt == '0 && tick_cnt == '0, "start did not launch a frame")

endmodule

@@ src/mdiom_out_reg.sv @@
// ---------------------------------------------------------------------------
// MDIO master result register
// Holds one result beat until the receiver takes it.
// ---------------------------------------------------------------------------
module mdiom_out_reg import mdiom_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  result_t result_in,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result_q
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result_in;
    end
  end

endmodule

@@ src/mdio_master_controller.sv @@
// ---------------------------------------------------------------------------
// MDIO master controller
// Register-driven clause 22 / clause 45 management frame master.
// ---------------------------------------------------------------------------
// Each input beat is a bus read, a bus write or one tick of the bit clock,
// with the MDIO pin level sampled on that tick. Each input beat gives exactly
// one result beat: the read value (zero unless a read) and the MDC, MDIO and
// drive-enable pin levels plus busy, all as they stand after that beat.
// Both channels use valid and stall. A beat passes through an input register
// and the engine into a result register, and a new beat is accepted every
// cycle while the result side keeps up.
// When the receiver stalls, the result register holds, the input register
// fills, and only then is the input stalled; nothing is dropped.
// Reset is synchronous: divider 255, clause 22, all other registers zero, no
// frame running and both registers empty.
// A frame is started by writing the command register with the start bit while
// not busy; it then runs for (divider+1) ticks per bit over 64 bits.
// ---------------------------------------------------------------------------
module mdio_master_controller import mdiom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [6:0]  reg_offset,
  input  logic [31:0] write_data,
  input  logic        mdio_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        mdc,
  output logic        mdio_out,
  output logic        mdio_drive,
  output logic        busy_res
);

  item_t   item_in;
  item_t   item_q;
  logic    item_valid;
  logic    ready;
  logic    fire;
  result_t result_c;
  result_t result_q;

  assign item_in = '{mode: mode, reg_offset: reg_offset, write_data: write_data,
                     mdio_in: mdio_in};
  assign fire    = item_valid && ready;

  mdiom_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_in    (item_in),
    .advance    (ready),
    .item_valid (item_valid),
    .item_q     (item_q)
  );

  mdiom_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .result (result_c)
  );

  mdiom_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .result_in (result_c),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_q  (result_q)
  );

  assign read_data  = result_q.read_data;
  assign mdc        = result_q.mdc;
  assign mdio_out   = result_q.mdio_out;
  assign mdio_drive = result_q.mdio_drive;
  assign busy_res   = result_q.busy_res;

endmodule
